FILE: rtl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared widths, register reset value and sequencer states for the centred
// moving mean.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] WINDOW_HALF_RESET = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB,
        ST_DECIDE,
        ST_START,
        ST_DIV,
        ST_OUT,
        ST_FL_SUB
    } t_state;

endpackage

FILE: rtl/cmm_div.sv
// ----------------------------------------------------------------------------
// cmm_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, quotient
// truncated toward zero and cut to the sample width.
// ----------------------------------------------------------------------------
module cmm_div
    import cmm_pkg::*;
#(
    parameter int SUM_W = 30,
    parameter int CNT_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic        [CNT_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_quotient
);

    localparam int MAG_W = SUM_W;
    localparam int ITER_W = $clog2(MAG_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [CNT_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  signed_quo;

    assign mag   = i_dividend[SUM_W-1] ? MAG_W'(-i_dividend) : MAG_W'(i_dividend);
    assign trial = {r_rem, r_quo[MAG_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(MAG_W);
            end else if (r_busy) begin
                r_iter <= r_iter - 1'b1;
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            // shift the next dividend bit into the remainder, the quotient bit into r_quo
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quotient = signed_quo[SAMPLE_W-1:0];
    assign o_done     = r_done;

endmodule

FILE: rtl/centered_moving_mean_top.sv
// ----------------------------------------------------------------------------
// centered_moving_mean_top
// Centred moving mean over a frame with windows clipped at both frame edges.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_sample and i_frame_end; an item is
// taken on a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall carry o_mean and o_last, o_last flagging the final mean
// of a frame. The user writes the half window through i_cfg_wr_en /
// i_cfg_wr_data only while idle; the block does not enforce this. A write
// also restarts the frame. Mean j leaves once sample j+h has arrived; the item
// flagged frame_end releases all pending means, up to h+1, oldest first.
// Every mean an item releases passes through the bit-serial divider, which
// works over SUM_W = 24 + log2 ring depth bits, 30 by default, and the block
// takes no new item until the last of those means has left; receiver stalls
// hold it further. At a frame end each flushed mean whose window shrinks first
// costs a ring read and a subtract.
// The ring is a single-port-read memory of 2*MAX_HALF+2 entries.
// Reset (synchronous, active low) empties the frame and sets the half window
// to 2. While i_stall is high the current mean is held and no new item is
// taken.
// ----------------------------------------------------------------------------
module centered_moving_mean_top
    import cmm_pkg::*;
#(
    parameter int MAX_HALF = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_frame_end,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_mean,
    output logic                       o_last,
    input  logic                       i_cfg_wr_en,
    input  logic        [CFG_W-1:0]    i_cfg_wr_data
);

    localparam int RING_LEN = 2 * MAX_HALF + 2;
    localparam int AW       = $clog2(RING_LEN);
    localparam int FC_W     = $clog2(RING_LEN + 1);
    localparam int SUM_W    = SAMPLE_W + AW;

    t_state r_state, n_state;

    logic [CFG_W-1:0]        r_window_half;
    logic [AW-1:0]           r_wp;
    logic [FC_W-1:0]         r_fc;
    logic signed [SUM_W-1:0] r_sum;
    logic [AW-1:0]           r_newest;
    logic [AW-1:0]           r_n;
    logic                    r_flush;
    logic [AW-1:0]           r_k;
    logic [AW-1:0]           r_span;

    logic signed [SAMPLE_W-1:0] r_ring [RING_LEN];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic                accept;
    logic [CFG_W-1:0]    h_sat;
    logic [AW-1:0]       h_a;
    logic [AW-1:0]       two_h;
    logic [AW-1:0]       two_h1;
    logic [FC_W-1:0]     fc_inc;
    logic [AW-1:0]       n_new;
    logic [AW-1:0]       back;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       k_max;
    logic [AW-1:0]       k_max_h;
    logic [AW-1:0]       span_first;
    logic [AW-1:0]       k_dec;
    logic [AW-1:0]       k_dec_h;
    logic [AW-1:0]       span_next;
    logic                div_start;
    logic                div_done;
    logic [AW-1:0]       div_count;
    logic signed [SUM_W-1:0] rd_ext;

    // half window, saturated at the ring's reach
    assign h_sat  = (int'(r_window_half) > MAX_HALF) ? CFG_W'(MAX_HALF) : r_window_half;
    assign h_a    = AW'(h_sat);
    assign two_h  = AW'({h_a, 1'b0});
    assign two_h1 = two_h + 1'b1;

    assign accept = i_valid && !o_stall;
    assign fc_inc = (r_fc < FC_W'(RING_LEN)) ? r_fc + 1'b1 : r_fc;
    assign n_new  = AW'(fc_inc - 1'b1);
    assign rd_ext = {{(SUM_W - SAMPLE_W){r_rd_data[SAMPLE_W-1]}}, r_rd_data};

    // first flush mean covers the newest min(n, kmax+h)+1 samples
    assign k_max      = (h_a < r_n) ? h_a : r_n;
    assign k_max_h    = k_max + h_a;
    assign span_first = (k_max_h < r_n) ? k_max_h : r_n;

    assign k_dec     = r_k - 1'b1;
    assign k_dec_h   = k_dec + h_a;
    assign span_next = (k_dec_h < r_n) ? k_dec_h : r_n;

    assign rd_addr = (r_newest >= back)
                   ? AW'(r_newest - back)
                   : AW'({1'b0, r_newest} + (AW + 1)'(RING_LEN) - {1'b0, back});

    assign div_count = r_span + 1'b1;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SUB_RD;
                end
            end
            ST_SUB_RD: begin
                n_state = (r_flush && (r_k != k_max)) ? ST_FL_SUB : ST_SUB;
            end
            ST_SUB: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_flush || (r_n >= h_a)) begin
                    n_state = ST_START;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    if (r_flush && (r_k != '0)) begin
                        n_state = (span_next < r_span) ? ST_SUB_RD : ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FL_SUB: begin
                n_state = ST_START;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        div_start = 1'b0;
        back      = r_span;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_SUB_RD: begin
                // drop-out sample of the window, or the oldest of a shrinking flush window
                back = r_flush && (r_k != k_max) ? r_span : two_h1;
            end
            ST_START: begin
                div_start = 1'b1;
            end
            ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                back = r_span;
            end
        endcase
    end

    assign o_last = r_flush && (r_k == '0);

    // ---------------------------------------------------------------- ring
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wp] <= i_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_half <= WINDOW_HALF_RESET;
            r_wp          <= '0;
            r_fc          <= '0;
            r_sum         <= '0;
            r_flush       <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_newest <= r_wp;
                        r_wp     <= (r_wp == AW'(RING_LEN - 1)) ? '0 : r_wp + 1'b1;
                        r_fc     <= fc_inc;
                        r_n      <= n_new;
                        r_sum    <= r_sum + {{(SUM_W - SAMPLE_W){i_sample[SAMPLE_W-1]}},
                                             i_sample};
                        r_flush  <= i_frame_end;
                        // r_k differs from k_max only mid-flush
                        r_k      <= (h_a < n_new) ? h_a : n_new;
                        r_span   <= '0;
                    end
                end
                ST_SUB: begin
                    if (r_n >= two_h1) begin
                        r_sum <= r_sum - rd_ext;
                    end
                end
                ST_FL_SUB: begin
                    // drop the oldest sample of a shrinking flush window
                    r_sum  <= r_sum - rd_ext;
                    r_span <= r_span - 1'b1;
                end
                ST_DECIDE: begin
                    if (r_flush) begin
                        r_k    <= k_max;
                        r_span <= span_first;
                    end else begin
                        r_span <= (r_n < two_h) ? r_n : two_h;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        if (r_flush && (r_k != '0)) begin
                            r_k <= k_dec;
                        end else if (r_flush) begin
                            r_flush <= 1'b0;
                            r_wp    <= '0;
                            r_fc    <= '0;
                            r_sum   <= '0;
                        end
                    end
                end
                default: begin
                    r_flush <= r_flush;
                end
            endcase
            if (i_cfg_wr_en) begin
                r_window_half <= i_cfg_wr_data;
                r_wp          <= '0;
                r_fc          <= '0;
                r_sum         <= '0;
            end
        end
    end

    cmm_div #(
        .SUM_W (SUM_W),
        .CNT_W (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (div_count),
        .o_done     (div_done),
        .o_quotient (o_mean)
    );

endmodule

FILE: sim/tb_centered_moving_mean_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_centered_moving_mean_top
// Self-checking bench for the centred moving mean with clipped frame edges.
// Frames of samples go in under random pacing. A local model of the ring and
// the running sum predicts every mean and its last flag, and each mean that
// leaves the block is compared with the oldest prediction. The half window is
// rewritten between phases, 0 and 31 among the values.
// ----------------------------------------------------------------------------
module tb_centered_moving_mean_top
    import cmm_pkg::*;
();

    localparam int CMM_MAX_HALF  = 31;
    localparam int RING_DEPTH    = 2 * CMM_MAX_HALF + 2;
    localparam int RANDOM_ITEMS  = 180;
    localparam int SETTLE_CYCLES = 80;
    localparam int TAIL_CYCLES   = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean;
        logic                       last;
    } t_mean_item;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample      = '0;
    logic                       i_frame_end   = 1'b0;
    logic                       o_valid;
    logic                       i_stall       = 1'b0;
    logic signed [SAMPLE_W-1:0] o_mean;
    logic                       o_last;
    logic                       i_cfg_wr_en   = 1'b0;
    logic        [CFG_W-1:0]    i_cfg_wr_data = '0;

    // Model state
    logic signed [SAMPLE_W-1:0] ring_mdl [RING_DEPTH];
    longint                     run_sum;
    int unsigned                fill_count;
    int unsigned                wr_slot;
    logic        [CFG_W-1:0]    half_reg;

    t_mean_item expected_means [$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         random_sent    = 0;
    int         burst_left     = 0;
    int         stall_run      = 0;
    bit         tx_paced       = 1'b0;
    bit         rx_paced       = 1'b0;

    centered_moving_mean_top #(
        .MAX_HALF (CMM_MAX_HALF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mean        (o_mean),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d means still expected", $time, expected_means.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Mean predictor
    // ------------------------------------------------------------------------
    task automatic restart_frame_model();
        run_sum    = 0;
        fill_count = 0;
        wr_slot    = 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] ring_back(int unsigned back);
        return ring_mdl[(wr_slot + 2 * RING_DEPTH - 1 - back) % RING_DEPTH];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] trunc_mean(longint sum, int cnt);
        longint q;
        q = sum / cnt;
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic predict_means(input logic signed [SAMPLE_W-1:0] s, input logic fe);
        int unsigned h;
        int unsigned n;
        int unsigned span;
        int          k;
        longint      acc;
        t_mean_item  m;
        h = (half_reg > CMM_MAX_HALF) ? CMM_MAX_HALF : half_reg;
        ring_mdl[wr_slot] = s;
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        if (fill_count < RING_DEPTH) fill_count++;
        n = fill_count - 1;
        run_sum += s;
        if (n >= 2 * h + 1) run_sum -= ring_back(2 * h + 1);
        if (!fe) begin
            if (n >= h) begin
                span   = (n < 2 * h) ? n : 2 * h;
                m.mean = trunc_mean(run_sum, span + 1);
                m.last = 1'b0;
                expected_means.push_back(m);
            end
        end else begin
            // Flush the pending positions oldest first; windows shrink at the end
            for (k = (h < n) ? h : n; k >= 0; k--) begin
                span = (k + h < n) ? k + h : n;
                acc  = 0;
                for (int o = 0; o <= span; o++) acc += ring_back(o);
                m.mean = trunc_mean(acc, span + 1);
                m.last = (k == 0);
                expected_means.push_back(m);
            end
            restart_frame_model();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_mean_item want;
        if (o_valid && !i_stall) begin
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected mean %0d last %0b", $time, o_mean, o_last);
                mismatch_count++;
            end else begin
                want = expected_means.pop_front();
                if (o_mean !== want.mean) begin
                    $display("%0t: mean mismatch, expected %0d, actual %0d",
                             $time, want.mean, o_mean);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, o_last);
                    mismatch_count++;
                end
            end
        end
        if (stall_run == 0) begin
            stall_run <= $urandom_range(1, 7);
            i_stall   <= rx_paced && ($urandom_range(0, 2) == 0);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic fe);
        i_valid     <= 1'b1;
        i_sample    <= s;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_stall);
        predict_means(s, fe);
        if (tx_paced) begin
            if (burst_left == 0) begin
                // Drop valid for a gap, now and then a long one to land mid-divide
                i_valid <= 1'b0;
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(15, 45)
                                                    : $urandom_range(1, 6))
                    @(posedge i_clk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (expected_means.size() != 0) @(posedge i_clk);
        // Items that give no mean may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] h);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        half_reg = h;
        restart_frame_model();
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2:       v = SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
            default: v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_random_frame(input int len, input bit finish, input int hold_at);
        for (int i = 0; i < len; i++) begin
            if (i == hold_at) begin
                // Hold off until every mean so far has come back
                i_valid <= 1'b0;
                wait_drained();
            end
            send_item(pick_sample(), finish && (i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_sample_frames();
        send_item(SAMPLE_MAX, 1'b1);
        send_item(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_edge_clipping();
        // Reset half window, extremes in the sums, then a short frame
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(24'sd1, 1'b1);
        send_item(-24'sd7, 1'b0);
        send_item(24'sd2, 1'b1);
    endtask

    task automatic test_window_extremes();
        write_window(5'd0);
        send_item(24'sd5, 1'b0);
        send_item(-24'sd5, 1'b0);
        send_item(SAMPLE_MIN, 1'b1);
        write_window(5'd31);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(24'sd1, 1'b0);
        send_item(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_window_restart();
        // An unfinished short frame is discarded by the write
        write_window(5'd5);
        send_item(24'sd100, 1'b0);
        send_item(-24'sd300, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        write_window(5'd3);
        send_item(24'sd11, 1'b0);
        send_item(-24'sd4, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(24'sd9, 1'b1);
    endtask

    task automatic test_random_frames();
        int phase;
        int phase_sent;
        int len;
        int hold_at;
        int unsigned h;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0:       h = 1;
                1:       h = 0;
                2:       h = 31;
                3:       h = 7;
                default: h = $urandom_range(0, 31);
            endcase
            write_window(CFG_W'(h));
            tx_paced   = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_paced   = (phase != 0) && ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 8);
            phase_sent = 0;
            while (phase_sent < 40 && random_sent < RANDOM_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = $urandom_range(2, h + 1);
                    2:       len = $urandom_range(64, 70);
                    default: len = $urandom_range(h + 1, 2 * h + 8);
                endcase
                hold_at = (phase_sent == 0 && (phase == 2 || $urandom_range(0, 5) == 0))
                          ? len / 2 : -1;
                send_random_frame(len, 1'b1, hold_at);
                phase_sent  += len;
                random_sent += len;
            end
            // Now and then leave a frame open for the next write to cut short
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, h + 2);
                send_random_frame(len, 1'b0, -1);
                random_sent += len;
            end
            phase++;
        end
    endtask

    initial begin
        half_reg = WINDOW_HALF_RESET;
        restart_frame_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_sample_frames();
        test_edge_clipping();
        test_window_extremes();
        test_window_restart();
        test_random_frames();

        i_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_means.size() != 0) begin
            $display("%0t: %0d means never arrived", $time, expected_means.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
